// ===== rtl/bfip_pkg.sv =====
// Package for the join Bloom filter insert and probe block.
// Holds the transfer payload types, register indexes and fixed field widths.
// Has no dependencies.
package bfip_pkg;

  localparam int unsigned SIZE_W     = 17;
  localparam int unsigned NH_W       = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned HASH_W     = 64;
  localparam int unsigned TOTAL_W    = 32;
  localparam int unsigned ROW_BITS   = 64;
  localparam int unsigned OFF_W      = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_HASHES  = 2'd2;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_PROBE  = 1'b1;

  typedef struct packed {
    logic              action;
    logic [HASH_W-1:0] key_hash;
    logic              hash_valid;
    logic              batch_end;
  } in_item_t;

  typedef struct packed {
    logic               maybe_present;
    logic [TOTAL_W-1:0] inserted_total;
    logic [TOTAL_W-1:0] probed_total;
    logic [TOTAL_W-1:0] filtered_total;
    logic               batch_end_out;
  } out_item_t;

endpackage

// ===== rtl/bfip_bit_store.sv =====
// Filter bit store: rows of bits with two registered read ports and one write port.
// Uses the row width from bfip_pkg.
module bfip_bit_store
  import bfip_pkg::*;
#(
  parameter int unsigned ROWS   = 1024,
  parameter int unsigned ADDR_W = 10
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr0,
  input  logic [ADDR_W-1:0]   rd_addr1,
  output logic [ROW_BITS-1:0] rd_data0,
  output logic [ROW_BITS-1:0] rd_data1,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  logic [ROW_BITS-1:0] wr_data
);

  logic [ROW_BITS-1:0] mem [ROWS];
  logic [ROW_BITS-1:0] rd_data0_r;
  logic [ROW_BITS-1:0] rd_data1_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0_r <= mem[rd_addr0];
      rd_data1_r <= mem[rd_addr1];
    end
  end

  assign rd_data0 = rd_data0_r;
  assign rd_data1 = rd_data1_r;

endmodule

// ===== rtl/bloom_filter_insert_probe_top.sv =====
// Top level of the join Bloom filter insert and probe block.
// Depends on bfip_pkg and bfip_bit_store.
//
// Items arrive on the in_ channel (valid and ready) as one in_item_t and each
// causes exactly one out_item_t on the out_ channel. An insert sets up to two
// bits of the filter; a probe reports whether all of its bits are set. The
// results carry saturating counts of inserts, probes and filtered probes.
// Configuration is written through cfg_we, cfg_addr and cfg_wdata; the user
// must write it only while idle, as the block itself does not enforce this.
// One item is in work at a time: a transfer in (S_IDLE), forming the bit
// indexes (S_HASH, multiply for the fast modulo mode), the memory read
// (S_READ), the check or write back (S_CHECK), and loading the result
// (S_DONE). An insert whose two bits lie in different rows also passes
// through S_WR2, since the bit store has a single write port. After reset
// the block clears the bit store one row per cycle; in_ready stays low meanwhile.
// A result waits in the output register while the receiver stalls; the next
// item is still accepted and proceeds until its own result needs that register.
module bloom_filter_insert_probe_top
  import bfip_pkg::*;
#(
  parameter int unsigned FILTER_BITS   = 65536,
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned ROWS   = (FILTER_BITS + ROW_BITS - 1) / ROW_BITS;
  localparam int unsigned ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned PROD_W = 32 + SIZE_W;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_HASH  = 7'b0000100,
    S_READ  = 7'b0001000,
    S_CHECK = 7'b0010000,
    S_WR2   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic              index_mode_r;
  logic [SIZE_W-1:0] filter_size_r;
  logic [NH_W-1:0]   num_hashes_r;

  in_item_t            item_r, item_nxt;
  logic [SIZE_W-1:0]   idx0_r, idx0_nxt;
  logic [SIZE_W-1:0]   idx1_r, idx1_nxt;
  logic                hit_r, hit_nxt;
  logic [ADDR_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [COUNTER_WIDTH-1:0] ins_cnt_r, ins_cnt_nxt;
  logic [COUNTER_WIDTH-1:0] prb_cnt_r, prb_cnt_nxt;
  logic [COUNTER_WIDTH-1:0] flt_cnt_r, flt_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_r, out_nxt;

  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr0, rd_addr1;
  logic [ROW_BITS-1:0] rd_data0, rd_data1;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ROW_BITS-1:0] wr_data;

  logic [SIZE_W-1:0]   size_eff;
  logic [PROD_W-1:0]   prod0, prod1;
  logic [ADDR_W-1:0]   row0, row1;
  logic [ROW_BITS-1:0] mask0, mask1;
  logic                bit0, bit1;
  logic                use1, use2;
  logic                same_row;

  function automatic logic [COUNTER_WIDTH-1:0] sat_inc(input logic [COUNTER_WIDTH-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_out(input logic [COUNTER_WIDTH-1:0] c);
    logic [63:0] c64;
    c64 = 64'(c);
    return (c64 > 64'h0000_0000_ffff_ffff) ? '1 : c64[TOTAL_W-1:0];
  endfunction

  bfip_bit_store #(
    .ROWS   (ROWS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk      (clk),
    .rd_en    (rd_en),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_mode_r  <= 1'b0;
      filter_size_r <= 17'd65536;
      num_hashes_r  <= 2'd2;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_INDEX_MODE:  index_mode_r  <= cfg_wdata[0];
        CFG_FILTER_SIZE: filter_size_r <= cfg_wdata;
        CFG_NUM_HASHES:  num_hashes_r  <= cfg_wdata[NH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    size_eff = filter_size_r;
    if (32'(filter_size_r) > 32'(FILTER_BITS)) begin
      size_eff = SIZE_W'(FILTER_BITS);
    end
    if (size_eff == '0) begin
      size_eff = SIZE_W'(1);
    end
  end

  assign prod0 = PROD_W'(item_r.key_hash[31:0]) * PROD_W'(size_eff);
  assign prod1 = PROD_W'(item_r.key_hash[63:32]) * PROD_W'(size_eff);

  assign row0     = ADDR_W'(idx0_r[SIZE_W-1:OFF_W]);
  assign row1     = ADDR_W'(idx1_r[SIZE_W-1:OFF_W]);
  assign mask0    = ROW_BITS'(1) << idx0_r[OFF_W-1:0];
  assign mask1    = ROW_BITS'(1) << idx1_r[OFF_W-1:0];
  assign bit0     = rd_data0[idx0_r[OFF_W-1:0]];
  assign bit1     = rd_data1[idx1_r[OFF_W-1:0]];
  assign use1     = (num_hashes_r != 2'd0);
  assign use2     = num_hashes_r[1];
  assign same_row = (row0 == row1);

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    idx0_nxt      = idx0_r;
    idx1_nxt      = idx1_r;
    hit_nxt       = hit_r;
    clr_cnt_nxt   = clr_cnt_r;
    ins_cnt_nxt   = ins_cnt_r;
    prb_cnt_nxt   = prb_cnt_r;
    flt_cnt_nxt   = flt_cnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    rd_en         = 1'b0;
    rd_addr0      = row0;
    rd_addr1      = row1;
    wr_en         = 1'b0;
    wr_addr       = row0;
    wr_data       = rd_data0 | mask0;

    unique case (state_r)
      S_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        wr_data     = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (index_mode_r) begin
          idx0_nxt = prod0[PROD_W-1:32];
          idx1_nxt = prod1[PROD_W-1:32];
        end else begin
          idx0_nxt = item_r.key_hash[SIZE_W-1:0] & (size_eff - 1'b1);
          idx1_nxt = item_r.key_hash[32+SIZE_W-1:32] & (size_eff - 1'b1);
        end
        state_nxt = S_READ;
      end
      S_READ: begin
        rd_en     = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = S_DONE;
        if (item_r.action == ACT_PROBE) begin
          hit_nxt     = item_r.hash_valid && (!use1 || bit0) && (!use2 || bit1);
          prb_cnt_nxt = sat_inc(prb_cnt_r);
          if (!hit_nxt) begin
            flt_cnt_nxt = sat_inc(flt_cnt_r);
          end
        end else begin
          hit_nxt     = 1'b0;
          ins_cnt_nxt = sat_inc(ins_cnt_r);
          if (item_r.hash_valid && use1) begin
            wr_en   = 1'b1;
            wr_data = (use2 && same_row) ? (rd_data0 | mask0 | mask1) : (rd_data0 | mask0);
            if (use2 && !same_row) begin
              state_nxt = S_WR2;
            end
          end
        end
      end
      S_WR2: begin
        wr_en     = 1'b1;
        wr_addr   = row1;
        wr_data   = rd_data1 | mask1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.maybe_present  = hit_r;
          out_nxt.inserted_total = sat_out(ins_cnt_r);
          out_nxt.probed_total   = sat_out(prb_cnt_r);
          out_nxt.filtered_total = sat_out(flt_cnt_r);
          out_nxt.batch_end_out  = item_r.batch_end;
          out_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      ins_cnt_r   <= '0;
      prb_cnt_r   <= '0;
      flt_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      ins_cnt_r   <= ins_cnt_nxt;
      prb_cnt_r   <= prb_cnt_nxt;
      flt_cnt_r   <= flt_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    idx0_r <= idx0_nxt;
    idx1_r <= idx1_nxt;
    hit_r  <= hit_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
